// ===== rtl/u8d_pkg.sv =====
`default_nettype none
package u8d_pkg;

  localparam int CpW  = 31;
  localparam int RemW = 3;

  // Largest count of continuation bytes a lead byte can announce
  localparam logic [RemW-1:0] MaxRem = 3'd5;

  typedef logic [7:0]      byte_t;
  typedef logic [CpW-1:0]  cp_t;
  typedef logic [RemW-1:0] rem_t;

  typedef struct packed {
    logic has;
    cp_t  code_point;
    logic truncated;
  } u8d_result_t;

endpackage
`default_nettype wire

// ===== rtl/u8d_byte_if.sv =====
`default_nettype none
interface u8d_byte_if;
  import u8d_pkg::*;

  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input data_byte, input end_of_buffer, output ready);

endinterface
`default_nettype wire

// ===== rtl/u8d_cp_if.sv =====
`default_nettype none
interface u8d_cp_if;
  import u8d_pkg::*;

  logic valid;
  logic ready;
  cp_t  code_point;
  logic truncated;

  modport source (output valid, output code_point, output truncated, input ready);
  modport sink   (input valid, input code_point, input truncated, output ready);

endinterface
`default_nettype wire

// ===== rtl/u8d_step.sv =====
`default_nettype none
module u8d_step
  import u8d_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        fire,
  input  wire byte_t       data_byte,
  input  wire logic        end_of_buffer,
  output u8d_result_t      res,
  output rem_t             bytes_left
);

  cp_t  pv_r, pv_nxt;
  rem_t rem_r, rem_nxt;
  rem_t rem_dec;
  cp_t  lead_pv;
  rem_t lead_cnt;
  logic lead_multi;

  assign rem_dec    = rem_r - 1'b1;
  assign bytes_left = rem_r;

  // Lead byte class, shortest prefix first
  always_comb begin
    lead_pv    = '0;
    lead_cnt   = '0;
    lead_multi = 1'b0;
    case (data_byte) inside
      8'b0???????: begin
        lead_pv = cp_t'(data_byte);
      end
      8'b10??????: begin
        lead_pv = '0;
      end
      8'b110?????: begin
        lead_pv    = cp_t'(data_byte[4:0]);
        lead_cnt   = 3'd1;
        lead_multi = 1'b1;
      end
      8'b1110????: begin
        lead_pv    = cp_t'(data_byte[3:0]);
        lead_cnt   = 3'd2;
        lead_multi = 1'b1;
      end
      8'b11110???: begin
        lead_pv    = cp_t'(data_byte[2:0]);
        lead_cnt   = 3'd3;
        lead_multi = 1'b1;
      end
      8'b111110??: begin
        lead_pv    = cp_t'(data_byte[1:0]);
        lead_cnt   = 3'd4;
        lead_multi = 1'b1;
      end
      8'b111111??: begin
        lead_pv    = cp_t'(data_byte[0]);
        lead_cnt   = MaxRem;
        lead_multi = 1'b1;
      end
      default: begin
        lead_pv = '0;
      end
    endcase
  end

  always_comb begin
    pv_nxt         = pv_r;
    rem_nxt        = rem_r;
    res.has        = 1'b0;
    res.code_point = '0;
    res.truncated  = 1'b0;
    if (rem_r == '0) begin
      if (!lead_multi) begin
        // ASCII or stray continuation: emit at once
        res.has        = 1'b1;
        res.code_point = lead_pv;
      end else if (end_of_buffer) begin
        res.has       = 1'b1;
        res.truncated = 1'b1;
        pv_nxt        = '0;
        rem_nxt       = '0;
      end else begin
        pv_nxt  = lead_pv;
        rem_nxt = lead_cnt;
      end
    end else begin
      if (rem_dec == '0) begin
        res.has        = 1'b1;
        res.code_point = {pv_r[CpW-7:0], data_byte[5:0]};
        pv_nxt         = '0;
        rem_nxt        = '0;
      end else if (end_of_buffer) begin
        res.has       = 1'b1;
        res.truncated = 1'b1;
        pv_nxt        = '0;
        rem_nxt       = '0;
      end else begin
        pv_nxt  = {pv_r[CpW-7:0], data_byte[5:0]};
        rem_nxt = rem_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r  <= '0;
      rem_r <= '0;
    end else if (fire) begin
      pv_r  <= pv_nxt;
      rem_r <= rem_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/utf8_stream_decoder.sv =====
// Path: a byte accepted into the input register is decoded there; its result, if any,
// loads into the result register once that register is free, and is offered from there.
// Throughput: one byte per cycle while the result side keeps taking transactions.
// The input register stalls only while the result register holds a pending item.
// Reset (rst_n low, synchronous): both channels empty, decode state cleared.
`default_nettype none
module utf8_stream_decoder
  import u8d_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  u8d_byte_if.sink  in_strm,
  u8d_cp_if.source  out_strm
);

  logic        s1_vld_r;
  byte_t       s1_byte_r;
  logic        s1_eob_r;
  logic        out_vld_r;
  cp_t         out_cp_r;
  logic        out_trunc_r;
  logic        out_free;
  logic        s1_fire;
  u8d_result_t res;
  rem_t        bytes_left;

  assign out_free       = !out_vld_r || out_strm.ready;
  assign s1_fire        = s1_vld_r && out_free;
  assign in_strm.ready  = !s1_vld_r || s1_fire;

  assign out_strm.valid      = out_vld_r;
  assign out_strm.code_point = out_cp_r;
  assign out_strm.truncated  = out_trunc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_strm.ready) begin
      s1_vld_r <= in_strm.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_strm.ready && in_strm.valid) begin
      s1_byte_r <= in_strm.data_byte;
      s1_eob_r  <= in_strm.end_of_buffer;
    end
  end

  u8d_step u_step (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (s1_fire),
    .data_byte     (s1_byte_r),
    .end_of_buffer (s1_eob_r),
    .res           (res),
    .bytes_left    (bytes_left)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= s1_fire && res.has;
    end
  end

  // Load the result register only when a transaction produces a result
  always_ff @(posedge clk) begin
    if (s1_fire && res.has) begin
      out_cp_r    <= res.code_point;
      out_trunc_r <= res.truncated;
    end
  end

`ifndef SYNTHESIS
  a_trunc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_trunc_r) |-> (out_cp_r == '0))
    else $error("truncated result carries a nonzero code point");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    bytes_left <= MaxRem)
    else $error("continuation count out of range");

  a_eob_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_eob_r) |=> (bytes_left == '0))
    else $error("decode state not cleared at end of buffer");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && !out_free) |=> (s1_vld_r && $stable(s1_byte_r)))
    else $error("input stage dropped a stalled byte");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
module tb;
  import u8d_pkg::*;

  localparam int RandItems = 1300;
  localparam int IdleLimit = 4000;
  localparam int DrainCycles = 8;

  // Lead-byte prefixes, tested longest first
  localparam byte_t Pfx6 = 8'hfc;
  localparam byte_t Pfx5 = 8'hf8;
  localparam byte_t Pfx4 = 8'hf0;
  localparam byte_t Pfx3 = 8'he0;
  localparam byte_t Pfx2 = 8'hc0;
  localparam byte_t AsciiMask = 8'h80;

  typedef struct packed {
    byte_t data_byte;
    logic  end_of_buffer;
  } utf8_byte_t;

  typedef struct packed {
    cp_t  code_point;
    logic truncated;
  } cp_rec_t;

  logic clk;
  logic rst_n;

  u8d_byte_if in_if ();
  u8d_cp_if   out_if ();

  utf8_stream_decoder u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_strm  (in_if),
    .out_strm (out_if)
  );

  utf8_byte_t byte_q[$];
  cp_rec_t    cp_q[$];

  // Decoder state mirror
  cp_t  acc_value;
  rem_t acc_remaining;

  int err_cnt;
  int idle_cycles;
  int gap_cnt;
  int burst_cnt;
  int stall_cnt;
  int stall_mode;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function void decode_byte(input byte_t b, input logic eob,
                            output logic has, output cp_rec_t rec);
    cp_t  payload;
    rem_t count;
    payload = '0;
    count   = '0;
    has     = 1'b0;
    rec     = '0;
    if (acc_remaining == '0) begin
      if ((b & AsciiMask) == '0) begin
        has = 1'b1;
        rec.code_point = cp_t'(b);
      end else begin
        if ((b & Pfx6) == Pfx6) begin
          payload = cp_t'(b[0]);
          count = 3'd5;
        end else if ((b & Pfx5) == Pfx5) begin
          payload = cp_t'(b[1:0]);
          count = 3'd4;
        end else if ((b & Pfx4) == Pfx4) begin
          payload = cp_t'(b[2:0]);
          count = 3'd3;
        end else if ((b & Pfx3) == Pfx3) begin
          payload = cp_t'(b[3:0]);
          count = 3'd2;
        end else if ((b & Pfx2) == Pfx2) begin
          payload = cp_t'(b[4:0]);
          count = 3'd1;
        end
        if (count == '0) begin
          // stray continuation in lead position
          has = 1'b1;
        end else if (eob) begin
          has = 1'b1;
          rec.truncated = 1'b1;
          acc_value = '0;
          acc_remaining = '0;
        end else begin
          acc_value = payload;
          acc_remaining = count;
        end
      end
    end else begin
      acc_value = {acc_value[CpW-7:0], b[5:0]};
      acc_remaining = acc_remaining - 3'd1;
      if (acc_remaining == '0) begin
        has = 1'b1;
        rec.code_point = acc_value;
        acc_value = '0;
      end else if (eob) begin
        has = 1'b1;
        rec.truncated = 1'b1;
        acc_value = '0;
        acc_remaining = '0;
      end
    end
  endfunction

  function void queue_byte(input byte_t b, input logic eob);
    utf8_byte_t it;
    it.data_byte = b;
    it.end_of_buffer = eob;
    byte_q.push_back(it);
  endfunction

  // Sequence with random payload, continuation bytes now and then random; sometimes cut short by end of buffer
  function int queue_sequence();
    int    len;
    int    cut;
    int    r;
    byte_t lead;
    byte_t b;
    r = $urandom_range(99);
    if (r < 30) len = 1;
    else if (r < 50) len = 2;
    else if (r < 65) len = 3;
    else if (r < 78) len = 4;
    else if (r < 89) len = 5;
    else len = 6;
    case (len)
      1: begin
        lead = {1'b0, 7'($urandom)};
      end
      2: begin
        lead = {3'b110, 5'($urandom)};
      end
      3: begin
        lead = {4'b1110, 4'($urandom)};
      end
      4: begin
        lead = {5'b11110, 3'($urandom)};
      end
      5: begin
        lead = {6'b111110, 2'($urandom)};
      end
      default: begin
        lead = {6'b111111, 2'($urandom)};
      end
    endcase
    cut = len;
    if (len > 1 && $urandom_range(14) == 0) cut = $urandom_range(len - 1, 1);
    for (int i = 0; i < cut; i++) begin
      if (i == 0) b = lead;
      else if ($urandom_range(7) == 0) b = byte_t'($urandom);
      else b = {2'b10, 6'($urandom)};
      queue_byte(b, (i == cut - 1) && (cut < len || $urandom_range(4) == 0));
    end
    return cut;
  endfunction

  // Sender: bursts of random length separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      if (in_if.valid) void'(byte_q.pop_front());
      if (gap_cnt != 0) begin
        gap_cnt <= gap_cnt - 1;
        in_if.valid <= 1'b0;
      end else if (byte_q.size() == 0) begin
        in_if.valid <= 1'b0;
      end else begin
        in_if.valid <= 1'b1;
        in_if.data_byte <= byte_q[0].data_byte;
        in_if.end_of_buffer <= byte_q[0].end_of_buffer;
        if (burst_cnt <= 1) begin
          burst_cnt <= ($urandom_range(5) == 0) ? $urandom_range(80, 30) : $urandom_range(16, 1);
          gap_cnt <= ($urandom_range(2) == 0) ? 0 : $urandom_range(6, 1);
        end else begin
          burst_cnt <= burst_cnt - 1;
        end
      end
    end
  end

  // Receiver: stall pattern is picked anew each time stall_cnt wraps to zero
  always @(posedge clk) begin
    if (stall_cnt == 0) stall_mode <= $urandom_range(3);
    stall_cnt <= (stall_cnt + 1) % 128;
    case (stall_mode)
      0: begin
        out_if.ready <= 1'b1;
      end
      1: begin
        out_if.ready <= 1'($urandom_range(1));
      end
      2: begin
        out_if.ready <= ($urandom_range(3) == 0);
      end
      default: begin
        out_if.ready <= stall_cnt[2];
      end
    endcase
  end

  // Check results in order, then predict from the accepted input transaction
  always @(posedge clk) begin : mon
    cp_rec_t want;
    cp_rec_t rec;
    logic    has;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        if (cp_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result cp=%h truncated=%b", $time,
                   out_if.code_point, out_if.truncated);
        end else begin
          want = cp_q.pop_front();
          if (out_if.code_point !== want.code_point) begin
            err_cnt++;
            $display("%0t: code_point expected %h actual %h", $time,
                     want.code_point, out_if.code_point);
          end
          if (out_if.truncated !== want.truncated) begin
            err_cnt++;
            $display("%0t: truncated expected %b actual %b", $time,
                     want.truncated, out_if.truncated);
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        decode_byte(in_if.data_byte, in_if.end_of_buffer, has, rec);
        if (has) cp_q.push_back(rec);
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= IdleLimit);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int n_items;
    in_if.valid = 1'b0;
    in_if.data_byte = '0;
    in_if.end_of_buffer = 1'b0;
    out_if.ready = 1'b0;
    acc_value = '0;
    acc_remaining = '0;
    err_cnt = 0;
    idle_cycles = 0;
    gap_cnt = 0;
    burst_cnt = 0;
    stall_cnt = 0;
    stall_mode = 0;
    rst_n = 1'b0;

    // ASCII extremes, stray continuations
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h7f, 1'b1);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'hbf, 1'b1);
    // two- and three-byte, the latter ending the buffer on its last byte
    queue_byte(8'hc2, 1'b0);
    queue_byte(8'ha9, 1'b0);
    queue_byte(8'he2, 1'b0);
    queue_byte(8'h82, 1'b0);
    queue_byte(8'hac, 1'b1);
    // six-byte lead with payload bit set: largest code point
    queue_byte(8'hfd, 1'b0);
    for (int i = 0; i < 5; i++) queue_byte(8'hbf, 1'b0);
    // buffer ends on a lead byte of the 0xFF kind
    queue_byte(8'hff, 1'b1);
    // buffer ends on a middle continuation
    queue_byte(8'hf8, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h40, 1'b1);
    // continuation top bits ignored
    queue_byte(8'hf4, 1'b0);
    queue_byte(8'hff, 1'b0);
    queue_byte(8'h3f, 1'b0);
    queue_byte(8'hc0, 1'b0);

    n_items = 0;
    while (n_items < RandItems) begin
      if ($urandom_range(99) < 82) begin
        n_items += queue_sequence();
      end else begin
        queue_byte(byte_t'($urandom), $urandom_range(9) == 0);
        n_items++;
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    wait (byte_q.size() == 0);
    // let the monitor record the last transaction's prediction
    @(posedge clk);
    while (cp_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/u8d_pkg.sv
rtl/u8d_byte_if.sv
rtl/u8d_cp_if.sv
rtl/u8d_step.sv
rtl/utf8_stream_decoder.sv
tb/sv/tb.sv
